@@ rtl/tss_pkg.sv @@
// Shared constants for the tagged selection sorter.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int KEY_BITS      = 32;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int TAG_BITS_DEF  = 8;

  // APB register file: one register, decoded on paddr[2]
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_DESCENDING = 1'b0;

endpackage

@@ rtl/tagged_selection_sort.sv @@
// Top level of the tagged selection sorter: APB register, store and sequencer.
// Each accepted transaction is written to the store unless it is full; on the
//   last one the stored pairs are selection sorted, then drained ascending or
//   descending as the register selects.
// One shared signed comparator and one store read port serve the sort; input
//   is stalled while sorting and draining.
// Reset: rst_ni clears the item count, sequencer and descending; store is unset.
`timescale 1ns / 1ps

module tagged_selection_sort #(
  parameter int MAX_ITEMS = tss_pkg::MAX_ITEMS_DEF,
  parameter int TAG_BITS  = tss_pkg::TAG_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tss_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [tss_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [tss_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  // input transactions
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tss_pkg::KEY_BITS-1:0]  sort_key_i,
  input  logic [TAG_BITS-1:0]                  item_tag_i,
  input  logic                                 in_last_i,
  // output transactions
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tss_pkg::KEY_BITS-1:0]  out_key_o,
  output logic [TAG_BITS-1:0]                  out_tag_o,
  output logic                                 out_last_o
);

  localparam int AW = $clog2(MAX_ITEMS);

  // ---------------------------------------------------------------------
  // Config register. Only register 0 exists; paddr[2] picks the slot and
  // the low byte-lane bits are ignored. Writes land on the access phase.
  // ---------------------------------------------------------------------
  logic descending_q;
  logic reg_sel;

  assign reg_sel = (paddr[2] == tss_pkg::REG_DESCENDING);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      descending_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[0] = descending_q;
    end
  end

  // ---------------------------------------------------------------------
  // Store <-> sequencer. The store has one write port and one registered
  // read port; the sequencer streams one read per cycle during a pass and
  // keeps the running minimum in registers, then swaps in two writes.
  // ---------------------------------------------------------------------
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [tss_pkg::KEY_BITS-1:0] mem_wkey;
  logic [TAG_BITS-1:0]          mem_wtag;
  logic [AW-1:0]                mem_raddr;
  logic [tss_pkg::KEY_BITS-1:0] mem_rkey;
  logic [TAG_BITS-1:0]          mem_rtag;

  tss_store #(
    .MAX_ITEMS (MAX_ITEMS),
    .TAG_BITS  (TAG_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_key_i  (mem_wkey),
    .wr_tag_i  (mem_wtag),
    .rd_addr_i (mem_raddr),
    .rd_key_o  (mem_rkey),
    .rd_tag_o  (mem_rtag)
  );

  tss_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .TAG_BITS  (TAG_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .descending_i (descending_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sort_key_i   (sort_key_i),
    .item_tag_i   (item_tag_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_key_o    (out_key_o),
    .out_tag_o    (out_tag_o),
    .out_last_o   (out_last_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wkey_o   (mem_wkey),
    .mem_wtag_o   (mem_wtag),
    .mem_raddr_o  (mem_raddr),
    .mem_rkey_i   (mem_rkey),
    .mem_rtag_i   (mem_rtag)
  );

endmodule

@@ rtl/tss_store.sv @@
// Key/tag store: one write port, one registered read port.
`timescale 1ns / 1ps

module tss_store #(
  parameter int MAX_ITEMS = tss_pkg::MAX_ITEMS_DEF,
  parameter int TAG_BITS  = tss_pkg::TAG_BITS_DEF,
  localparam int AW       = $clog2(MAX_ITEMS)
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [tss_pkg::KEY_BITS-1:0] wr_key_i,
  input  logic [TAG_BITS-1:0]          wr_tag_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [tss_pkg::KEY_BITS-1:0] rd_key_o,
  output logic [TAG_BITS-1:0]          rd_tag_o
);

  logic [tss_pkg::KEY_BITS-1:0] key_mem [MAX_ITEMS];
  logic [TAG_BITS-1:0]          tag_mem [MAX_ITEMS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_o <= key_mem[rd_addr_i];
    rd_tag_o <= tag_mem[rd_addr_i];
  end

endmodule

@@ rtl/tss_ctrl.sv @@
// Sequencer and shared key comparator for load, selection sort and drain.
`timescale 1ns / 1ps

module tss_ctrl #(
  parameter int MAX_ITEMS = tss_pkg::MAX_ITEMS_DEF,
  parameter int TAG_BITS  = tss_pkg::TAG_BITS_DEF,
  localparam int AW       = $clog2(MAX_ITEMS),
  localparam int CW       = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                descending_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tss_pkg::KEY_BITS-1:0] sort_key_i,
  input  logic [TAG_BITS-1:0]                 item_tag_i,
  input  logic                                in_last_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tss_pkg::KEY_BITS-1:0] out_key_o,
  output logic [TAG_BITS-1:0]                 out_tag_o,
  output logic                                out_last_o,
  // store
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [tss_pkg::KEY_BITS-1:0]        mem_wkey_o,
  output logic [TAG_BITS-1:0]                 mem_wtag_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  logic [tss_pkg::KEY_BITS-1:0]        mem_rkey_i,
  input  logic [TAG_BITS-1:0]                 mem_rtag_i
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                pos_q, pos_d;
  logic [CW-1:0]                iss_q, iss_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [CW-1:0]                rd_idx_q, rd_idx_d;
  logic [CW-1:0]                best_idx_q, best_idx_d;
  logic [tss_pkg::KEY_BITS-1:0] best_key_q, best_key_d;
  logic [TAG_BITS-1:0]          best_tag_q, best_tag_d;
  logic [tss_pkg::KEY_BITS-1:0] pos_key_q, pos_key_d;
  logic [TAG_BITS-1:0]          pos_tag_q, pos_tag_d;
  logic [CW-1:0]                k_q, k_d;
  logic                         out_vld_q, out_vld_d;
  logic [tss_pkg::KEY_BITS-1:0] out_key_q, out_key_d;
  logic [TAG_BITS-1:0]          out_tag_q, out_tag_d;
  logic                         out_last_q, out_last_d;

  logic          full;
  logic [CW-1:0] n_new;
  logic [CW-1:0] src;
  logic          key_less;

  assign full     = (cnt_q == CW'(MAX_ITEMS));
  assign n_new    = full ? cnt_q : cnt_q + CW'(1);
  assign src      = descending_i ? (cnt_q - CW'(1) - k_q) : k_q;
  // the one comparator: strictly below keeps the first of equal keys
  assign key_less = $signed(mem_rkey_i) < $signed(best_key_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    iss_d      = iss_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    best_idx_d = best_idx_q;
    best_key_d = best_key_q;
    best_tag_d = best_tag_q;
    pos_key_d  = pos_key_q;
    pos_tag_d  = pos_tag_q;
    k_d        = k_q;
    out_vld_d  = out_vld_q;
    out_key_d  = out_key_q;
    out_tag_d  = out_tag_q;
    out_last_d = out_last_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AW-1:0];
    mem_wkey_o  = sort_key_i;
    mem_wtag_o  = item_tag_i;
    mem_raddr_o = iss_q[AW-1:0];

    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (!full) begin
            mem_we_o = 1'b1;
            cnt_d    = cnt_q + CW'(1);
          end
          if (in_last_i) begin
            pos_d    = '0;
            iss_d    = '0;
            rd_vld_d = 1'b0;
            k_d      = '0;
            state_d  = (n_new > CW'(1)) ? ST_SCAN : ST_OUT_RD;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, consume the one issued last cycle
        if (iss_q != cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q;
          iss_d    = iss_q + CW'(1);
        end else begin
          rd_vld_d = 1'b0;
          state_d  = ST_SWAP_A;
        end
        if (rd_vld_q) begin
          if (rd_idx_q == pos_q) begin
            best_idx_d = pos_q;
            best_key_d = mem_rkey_i;
            best_tag_d = mem_rtag_i;
            pos_key_d  = mem_rkey_i;
            pos_tag_d  = mem_rtag_i;
          end else if (key_less) begin
            best_idx_d = rd_idx_q;
            best_key_d = mem_rkey_i;
            best_tag_d = mem_rtag_i;
          end
        end
      end

      ST_SWAP_A: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AW-1:0];
        mem_wkey_o  = best_key_q;
        mem_wtag_o  = best_tag_q;
        state_d     = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = best_idx_q[AW-1:0];
        mem_wkey_o  = pos_key_q;
        mem_wtag_o  = pos_tag_q;
        pos_d       = pos_q + CW'(1);
        iss_d       = pos_q + CW'(1);
        k_d         = '0;
        state_d     = ((pos_q + CW'(2)) < cnt_q) ? ST_SCAN : ST_OUT_RD;
      end

      ST_OUT_RD: begin
        mem_raddr_o = src[AW-1:0];
        state_d     = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        out_vld_d  = 1'b1;
        out_key_d  = mem_rkey_i;
        out_tag_d  = mem_rtag_i;
        out_last_d = ((k_q + CW'(1)) == cnt_q);
        k_d        = k_q + CW'(1);
        state_d    = ST_OUT_WAIT;
      end

      ST_OUT_WAIT: begin
        // prefetch the next entry; it is used only once this one leaves
        mem_raddr_o = src[AW-1:0];
        if (!out_stall_i) begin
          out_vld_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_OUT_LD;
          end
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      pos_q      <= '0;
      iss_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      best_idx_q <= '0;
      best_key_q <= '0;
      best_tag_q <= '0;
      pos_key_q  <= '0;
      pos_tag_q  <= '0;
      k_q        <= '0;
      out_vld_q  <= 1'b0;
      out_key_q  <= '0;
      out_tag_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      iss_q      <= iss_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      best_idx_q <= best_idx_d;
      best_key_q <= best_key_d;
      best_tag_q <= best_tag_d;
      pos_key_q  <= pos_key_d;
      pos_tag_q  <= pos_tag_d;
      k_q        <= k_d;
      out_vld_q  <= out_vld_d;
      out_key_q  <= out_key_d;
      out_tag_q  <= out_tag_d;
      out_last_q <= out_last_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;

endmodule
